// ===== rtl/core/rcf_pkg.sv =====
// types, codes and sizes shared by the record chunk framer
`timescale 1ns / 1ps
package rcf_pkg;

    localparam int BUFFER_BYTES       = 4096;
    localparam int ADDR_W             = $clog2(BUFFER_BYTES);
    localparam int HEADER_BYTES       = 80;
    localparam int ENTRY_HEADER_BYTES = 28;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_VALUE  = 3'd1,
        REQ_SEAL   = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_READ   = 3'd4,
        REQ_QUERY  = 3'd5
    } t_req_code;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_REJECT   = 3'd1,
        ST_NEED     = 3'd2,
        ST_SEALED   = 3'd3,
        ST_NOTHING  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_TARGET   = 2'd1,
        CFG_MAX_AGE  = 2'd2,
        CFG_ENCODING = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_SEAL,
        S_READ
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] rec_stream;
        logic [63:0] span_hi;
        logic [63:0] span_lo;
        logic [31:0] seq_number;
        logic [63:0] mono_time_us;
        logic signed [63:0] utc_time_ns;
        logic [15:0] value_length;
        logic [7:0]  value_byte;
        logic [31:0] now_ms;
        logic [31:0] chunk_seq;
        logic [11:0] read_address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        record_held;
        logic        age_exceeded;
        logic [12:0] payload_length;
        logic [7:0]  read_data;
    } t_rsp;

    // byte i of a little-endian word
    function automatic logic [7:0] le_byte(input logic [63:0] v, input logic [2:0] i);
        return v[{i, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/core/record_chunk_framer.sv =====
// record chunk framer top level: request sequencer around the chunk buffer memory
`timescale 1ns / 1ps
// Requests are taken on start while busy is low; each gives exactly one result,
// strobed on o_valid for one cycle, which the receiver must take. Query, clear
// and value-byte requests finish at once and busy stays low. A read passes
// through the S_READ state for the registered memory read. An accepted append
// keeps busy high while the entry, (28 + length + 3) & ~3 bytes, is written one
// byte a cycle. A seal writes the 80-byte chunk header. The buffer has a single
// byte write port. Buffer bytes that were never written read back as undefined.
module record_chunk_framer
    import rcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_valid,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [7:0] mem [BUFFER_BYTES];

    t_state      r_state, n_state;
    logic [12:0] r_capacity, r_target;
    logic [31:0] r_max_age;
    logic [15:0] r_encoding;

    logic        r_holding, n_holding;
    logic [15:0] r_stream, n_stream;
    logic [63:0] r_span0, n_span0, r_span1, n_span1;
    logic [31:0] r_total, n_total;
    logic [31:0] r_seq0, n_seq0, r_seq1, n_seq1;
    logic [63:0] r_mono0, n_mono0, r_mono1, n_mono1;
    logic [63:0] r_utc0, n_utc0, r_utc1, n_utc1;
    logic [12:0] r_wofs, n_wofs;
    logic [31:0] r_first, n_first;
    logic [12:0] r_cursor, n_cursor;
    logic [15:0] r_pending, n_pending;

    logic [12:0] r_base, n_base;
    logic [12:0] r_cnt, n_cnt;
    logic [12:0] r_end, n_end;
    logic [31:0] r_chunk_seq, n_chunk_seq;

    logic        r_valid, n_valid;
    t_rsp        r_rsp, n_rsp;
    logic [7:0]  r_rdata;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        wdata;

    logic        accept;
    logic [16:0] entry_bytes;
    logic [12:0] cap;
    logic [17:0] end_sum;
    logic        mismatch;
    logic [7:0]  fill_byte, seal_byte;
    logic [12:0] body_len;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

    assign entry_bytes = ({1'b0, i_req.value_length} + 17'(ENTRY_HEADER_BYTES + 3)) & ~17'd3;
    assign cap       = (r_capacity > 13'(BUFFER_BYTES)) ? 13'(BUFFER_BYTES) : r_capacity;
    assign end_sum   = {5'b0, r_wofs} + {1'b0, entry_bytes};
    assign mismatch  = r_holding && (r_stream != i_req.rec_stream ||
                       r_span0 != i_req.span_hi || r_span1 != i_req.span_lo);
    assign body_len  = r_wofs - 13'(HEADER_BYTES);

    // entry header bytes, zero elsewhere and in the padding
    always_comb begin
        fill_byte = 8'h00;
        case (r_cnt) inside
            [13'd0 : 13'd3]:   fill_byte = le_byte({32'b0, r_seq1}, r_cnt[2:0]);
            [13'd8 : 13'd15]:  fill_byte = le_byte(r_mono1, r_cnt[2:0]);
            [13'd16 : 13'd23]: fill_byte = le_byte(r_utc1, r_cnt[2:0]);
            [13'd24 : 13'd25]: fill_byte = le_byte({48'b0, r_pending}, r_cnt[2:0]);
            default:           fill_byte = 8'h00;
        endcase
    end

    always_comb begin
        seal_byte = 8'h00;
        case (r_cnt) inside
            [13'd0 : 13'd1]:   seal_byte = le_byte({48'b0, r_stream}, r_cnt[2:0]);
            [13'd2 : 13'd3]:   seal_byte = le_byte({48'b0, r_encoding}, 3'(r_cnt - 13'd2));
            [13'd4 : 13'd7]:   seal_byte = le_byte({32'b0, r_chunk_seq}, 3'(r_cnt - 13'd4));
            [13'd8 : 13'd15]:  seal_byte = le_byte(r_span0, r_cnt[2:0]);
            [13'd16 : 13'd23]: seal_byte = le_byte(r_span1, r_cnt[2:0]);
            [13'd24 : 13'd27]: seal_byte = le_byte({32'b0, r_total}, r_cnt[2:0]);
            [13'd28 : 13'd31]: seal_byte = le_byte({32'b0, r_seq0}, 3'(r_cnt - 13'd28));
            [13'd32 : 13'd35]: seal_byte = le_byte({32'b0, r_seq1}, r_cnt[2:0]);
            [13'd40 : 13'd47]: seal_byte = le_byte(r_mono0, r_cnt[2:0]);
            [13'd48 : 13'd55]: seal_byte = le_byte(r_mono1, r_cnt[2:0]);
            [13'd56 : 13'd63]: seal_byte = le_byte(r_utc0, r_cnt[2:0]);
            [13'd64 : 13'd71]: seal_byte = le_byte(r_utc1, r_cnt[2:0]);
            [13'd72 : 13'd75]: seal_byte = le_byte({51'b0, body_len}, r_cnt[2:0]);
            default:           seal_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_holding   = r_holding;
        n_stream    = r_stream;
        n_span0     = r_span0;
        n_span1     = r_span1;
        n_total     = r_total;
        n_seq0      = r_seq0;
        n_seq1      = r_seq1;
        n_mono0     = r_mono0;
        n_mono1     = r_mono1;
        n_utc0      = r_utc0;
        n_utc1      = r_utc1;
        n_wofs      = r_wofs;
        n_first     = r_first;
        n_cursor    = r_cursor;
        n_pending   = r_pending;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_end       = r_end;
        n_chunk_seq = r_chunk_seq;
        n_valid     = 1'b0;
        n_rsp       = r_rsp;
        we          = 1'b0;
        waddr       = r_cursor[ADDR_W-1:0];
        wdata       = i_req.value_byte;
        raddr       = i_req.read_address;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rsp = '0;
                    n_valid = 1'b1;
                    case (i_req.req_type)
                        REQ_APPEND: begin
                            if (i_req.value_length == 16'd0 || mismatch ||
                                end_sum > {5'b0, cap}) begin
                                n_rsp.status = ST_REJECT;
                            end else begin
                                if (!r_holding) begin
                                    n_stream = i_req.rec_stream;
                                    n_span0  = i_req.span_hi;
                                    n_span1  = i_req.span_lo;
                                    n_seq0   = i_req.seq_number;
                                    n_mono0  = i_req.mono_time_us;
                                    n_utc0   = i_req.utc_time_ns;
                                    n_first  = i_req.now_ms;
                                end
                                n_seq1    = i_req.seq_number;
                                n_mono1   = i_req.mono_time_us;
                                n_utc1    = i_req.utc_time_ns;
                                n_total   = r_total + 32'd1;
                                n_holding = 1'b1;
                                n_base    = r_wofs;
                                n_cnt     = '0;
                                n_end     = end_sum[12:0] - r_wofs;
                                n_cursor  = r_wofs + 13'(ENTRY_HEADER_BYTES);
                                n_pending = i_req.value_length;
                                n_wofs    = end_sum[12:0];
                                n_rsp.status = (end_sum[12:0] >= r_target) ? ST_NEED : ST_OK;
                                n_state   = S_FILL;
                            end
                        end
                        REQ_VALUE: begin
                            if (r_pending != 16'd0) begin
                                we        = !r_cursor[ADDR_W];
                                n_cursor  = r_cursor + 13'd1;
                                n_pending = r_pending - 16'd1;
                            end else begin
                                n_rsp.status = ST_REJECT;
                            end
                        end
                        REQ_SEAL: begin
                            if (!r_holding) begin
                                n_rsp.status = ST_NOTHING;
                            end else begin
                                n_rsp.status         = ST_SEALED;
                                n_rsp.payload_length = r_wofs;
                                n_chunk_seq          = i_req.chunk_seq;
                                n_cnt                = '0;
                                n_state              = S_SEAL;
                            end
                        end
                        REQ_CLEAR: begin
                            n_holding = 1'b0;
                            n_total   = '0;
                            n_seq0    = '0;
                            n_seq1    = '0;
                            n_mono0   = '0;
                            n_mono1   = '0;
                            n_utc0    = '0;
                            n_utc1    = '0;
                            n_wofs    = 13'(HEADER_BYTES);
                            n_first   = '0;
                            n_cursor  = '0;
                            n_pending = '0;
                        end
                        REQ_READ: begin
                            // result goes out once the memory read returns
                            n_valid = 1'b0;
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.record_held  = n_holding;
                    n_rsp.age_exceeded = n_holding && ((i_req.now_ms - n_first) >= r_max_age);
                end
            end
            S_FILL: begin
                we    = 1'b1;
                waddr = ADDR_W'(r_base + r_cnt);
                wdata = fill_byte;
                n_cnt = r_cnt + 13'd1;
                if (n_cnt == r_end) begin
                    n_state = S_IDLE;
                end
            end
            S_SEAL: begin
                we    = 1'b1;
                waddr = r_cnt[ADDR_W-1:0];
                wdata = seal_byte;
                n_cnt = r_cnt + 13'd1;
                if (n_cnt == 13'(HEADER_BYTES)) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_rsp.read_data = r_rdata;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_holding <= 1'b0;
            r_stream  <= '0;
            r_span0   <= '0;
            r_span1   <= '0;
            r_total   <= '0;
            r_seq0    <= '0;
            r_seq1    <= '0;
            r_mono0   <= '0;
            r_mono1   <= '0;
            r_utc0    <= '0;
            r_utc1    <= '0;
            r_wofs    <= 13'(HEADER_BYTES);
            r_first   <= '0;
            r_cursor  <= '0;
            r_pending <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_holding <= n_holding;
            r_stream  <= n_stream;
            r_span0   <= n_span0;
            r_span1   <= n_span1;
            r_total   <= n_total;
            r_seq0    <= n_seq0;
            r_seq1    <= n_seq1;
            r_mono0   <= n_mono0;
            r_mono1   <= n_mono1;
            r_utc0    <= n_utc0;
            r_utc1    <= n_utc1;
            r_wofs    <= n_wofs;
            r_first   <= n_first;
            r_cursor  <= n_cursor;
            r_pending <= n_pending;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_end       <= n_end;
        r_chunk_seq <= n_chunk_seq;
        r_rsp       <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 13'd4096;
            r_target   <= 13'd2048;
            r_max_age  <= 32'd1000;
            r_encoding <= 16'd1;
        end else if (i_cfg_valid && i_cfg_index[2] == 1'b0) begin
            case (t_cfg_index'(i_cfg_index[1:0]))
                CFG_CAPACITY: r_capacity <= i_cfg_data[12:0];
                CFG_TARGET:   r_target   <= i_cfg_data[12:0];
                CFG_MAX_AGE:  r_max_age  <= i_cfg_data;
                CFG_ENCODING: r_encoding <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule
